// ===== src/value_noise_3d_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the value-noise core
// Shared forms for concurrent checks, sampled on the rising clock edge and
// disabled while the synchronous reset is high.
// ---------------------------------------------------------------------------
`ifndef VALUE_NOISE_3D_CORE_MACROS_SVH
`define VALUE_NOISE_3D_CORE_MACROS_SVH

// Overlapping implication: the consequent starts in the cycle of the antecedent.
`define VN3D_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// Non-overlapping implication: the consequent starts in the next cycle.
`define VN3D_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error(msg);

`endif

// ===== src/vn3d_pkg.sv =====
// ---------------------------------------------------------------------------
// vn3d_pkg
// Types, constants and arithmetic helpers shared by the value-noise core.
// ---------------------------------------------------------------------------
package vn3d_pkg;

  // Fraction bits of the incoming coordinates (range 8 to 24).
  localparam int unsigned COORD_FRAC_BITS = 16;
  // Fraction bits of the internal interpolation fraction and weights.
  localparam int unsigned WEIGHT_BITS = 16;
  // Register stages from an accepted item to its result strobe.
  localparam int unsigned PIPE_DEPTH = 11;

  typedef logic signed [31:0] coord_t;
  typedef logic [31:0] hash_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic signed [23:0] corner_t;
  typedef logic signed [25:0] lerp_prod_t;

  typedef struct packed {
    weight_t x;
    weight_t y;
    weight_t z;
  } wts_t;

  localparam hash_t HASH_PX = 32'd73856093;
  localparam hash_t HASH_PY = 32'd19349663;
  localparam hash_t HASH_PZ = 32'd83492791;
  localparam hash_t HASH_M1 = 32'h7feb352d;
  localparam hash_t HASH_M2 = 32'h846ca68b;

  // Second half of smoothstep: w = (t2 * (3*2^16 - 2*t)) >> 16, t2 = t*t >> 16.
  function automatic weight_t smooth_weight(weight_t t2, weight_t t);
    logic [17:0] k;
    logic [33:0] p;
    k = 18'd196608 - {1'b0, t, 1'b0};
    p = {18'b0, t2} * {16'b0, k};
    return p[31:16];
  endfunction

  // floor((b - a) * w / 2^16); the magnitude stays below 2^24.
  function automatic lerp_prod_t lerp_mul(corner_t a, corner_t b, weight_t w);
    logic signed [24:0] diff;
    logic signed [41:0] prod;
    diff = $signed({b[23], b}) - $signed({a[23], a});
    prod = diff * $signed({1'b0, w});
    return $signed(prod[41:16]);
  endfunction

  // a + step; the sum lies between the two lerp endpoints.
  function automatic corner_t lerp_add(corner_t a, lerp_prod_t p);
    logic signed [25:0] s;
    s = $signed({{2{a[23]}}, a}) + p;
    return $signed(s[23:0]);
  endfunction

endpackage

// ===== src/vn3d_hash.sv =====
// ---------------------------------------------------------------------------
// vn3d_hash
// Three-stage xorshift-multiply finalizer that turns a mixed corner hash
// into a signed Q0.23 lattice value.
// ---------------------------------------------------------------------------
module vn3d_hash (
  input  logic            clk,
  input  vn3d_pkg::hash_t h,
  output vn3d_pkg::corner_t value
);
  import vn3d_pkg::*;

  hash_t m1;
  hash_t m2;
  hash_t fin;

  assign fin = m2 ^ (m2 >> 16);

  always_ff @(posedge clk) begin
    m1 <= (h ^ (h >> 16)) * HASH_M1;
    m2 <= (m1 ^ (m1 >> 15)) * HASH_M2;
    // Low 24 bits minus 2^23 is the same as flipping bit 23.
    value <= $signed({~fin[23], fin[22:0]});
  end

endmodule

// ===== src/value_noise_3d_core.sv =====
// ---------------------------------------------------------------------------
// value_noise_3d_core
// A result strobes on done when its item leaves the last pipeline stage.
// Throughput: one item per cycle; busy stays low because the receiver
// cannot stall and the eleven-stage pipeline never has to hold.
// Reset clears the stage valid bits and sets the seed to zero. The seed
// channel is ready only while no item is in flight.
// ---------------------------------------------------------------------------
`include "value_noise_3d_core_macros.svh"

module value_noise_3d_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  vn3d_pkg::coord_t  pos_x,
  input  vn3d_pkg::coord_t  pos_y,
  input  vn3d_pkg::coord_t  pos_z,
  output logic              done,
  output vn3d_pkg::corner_t noise_value,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  vn3d_pkg::hash_t   noise_seed
);
  import vn3d_pkg::*;

  // The pipeline always advances, so an item is taken whenever start is high.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // One valid bit per stage travels alongside the data.
  logic [PIPE_DEPTH-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], accept};
    end
  end
  assign done = vld[PIPE_DEPTH-1];

  // The seed may only change while the pipeline is empty. An item taken at
  // the same edge as a seed write already sees the new seed in stage 2.
  assign cfg_ready = ~|vld;

  // Seed register. Because it is only rewritten while no item is in flight,
  // the hash stage reads it directly instead of carrying a copy per item.
  hash_t seed;
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_valid && cfg_ready) begin
      seed <= noise_seed;
    end
  end

  // Stage 1: split every coordinate into its floor cell and a Q0.16
  // fraction. The cell is multiplied by its axis prime right away, and the
  // fraction is squared for the smoothstep weight.
  localparam hash_t HASH_P [3] = '{HASH_PX, HASH_PY, HASH_PZ};

  coord_t  pos_a  [3];
  coord_t  cell_c [3];
  weight_t frac_c [3];
  logic [31:0] sq_c [3];

  assign pos_a[0] = pos_x;
  assign pos_a[1] = pos_y;
  assign pos_a[2] = pos_z;

  hash_t   s1_prod [3];
  weight_t s1_frac [3];
  weight_t s1_tsq  [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign cell_c[a] = pos_a[a] >>> COORD_FRAC_BITS;
    // A wider fraction drops its low bits; a narrower one is zero-filled.
    if (COORD_FRAC_BITS >= WEIGHT_BITS) begin : g_trim
      assign frac_c[a] = pos_a[a][COORD_FRAC_BITS-1 -: WEIGHT_BITS];
    end else begin : g_fill
      assign frac_c[a] = {pos_a[a][COORD_FRAC_BITS-1:0],
                          {(WEIGHT_BITS-COORD_FRAC_BITS){1'b0}}};
    end
    assign sq_c[a] = {16'b0, frac_c[a]} * {16'b0, frac_c[a]};

    always_ff @(posedge clk) begin
      s1_prod[a] <= $unsigned(cell_c[a]) * HASH_P[a];
      s1_frac[a] <= frac_c[a];
      s1_tsq[a]  <= sq_c[a][31:16];
    end
  end

  // Stage 2: mix the seed with the per-axis products for all eight corners.
  // The far corner's product is (cell + 1) * P, which modulo 2^32 is simply
  // the near product plus P, so no second multiplier is needed. At the top
  // of the cell range the far cell does not wrap; the 32-bit add covers it.
  // Corner index bit 0 picks x, bit 1 picks y and bit 2 picks z.
  hash_t prod_far [3];
  for (genvar a = 0; a < 3; a++) begin : g_far
    assign prod_far[a] = s1_prod[a] + HASH_P[a];
  end

  hash_t s2_h [8];
  wts_t  s2_w;

  for (genvar c = 0; c < 8; c++) begin : g_mix
    always_ff @(posedge clk) begin
      s2_h[c] <= seed
               ^ (c[0] ? prod_far[0] : s1_prod[0])
               ^ (c[1] ? prod_far[1] : s1_prod[1])
               ^ (c[2] ? prod_far[2] : s1_prod[2]);
    end
  end

  always_ff @(posedge clk) begin
    s2_w.x <= smooth_weight(s1_tsq[0], s1_frac[0]);
    s2_w.y <= smooth_weight(s1_tsq[1], s1_frac[1]);
    s2_w.z <= smooth_weight(s1_tsq[2], s1_frac[2]);
  end

  // Stages 3 to 5: the finalizer, in eight copies; stages 3 and 4 each hold one multiply.
  // Its output is the corner value in Q0.23.
  corner_t cv [8];
  for (genvar c = 0; c < 8; c++) begin : g_hash
    vn3d_hash u_hash (
      .clk   (clk),
      .h     (s2_h[c]),
      .value (cv[c])
    );
  end

  // The weights ride along until the lerp stage that uses them.
  wts_t w_pipe [3:9];
  always_ff @(posedge clk) begin
    w_pipe[3] <= s2_w;
    for (int k = 4; k <= 9; k++) begin
      w_pipe[k] <= w_pipe[k-1];
    end
  end

  // Stages 6 and 7: four lerps along x. Each lerp takes two stages, one
  // for the signed multiply and one for the add.
  lerp_prod_t s6_p [4];
  corner_t    s6_a [4];
  corner_t    lx   [4];

  for (genvar i = 0; i < 4; i++) begin : g_lx
    always_ff @(posedge clk) begin
      s6_p[i] <= lerp_mul(cv[2*i], cv[2*i+1], w_pipe[5].x);
      s6_a[i] <= cv[2*i];
      lx[i]   <= lerp_add(s6_a[i], s6_p[i]);
    end
  end

  // Stages 8 and 9: two lerps along y.
  lerp_prod_t s8_p [2];
  corner_t    s8_a [2];
  corner_t    ly   [2];

  for (genvar j = 0; j < 2; j++) begin : g_ly
    always_ff @(posedge clk) begin
      s8_p[j] <= lerp_mul(lx[2*j], lx[2*j+1], w_pipe[7].y);
      s8_a[j] <= lx[2*j];
      ly[j]   <= lerp_add(s8_a[j], s8_p[j]);
    end
  end

  // Stages 10 and 11: the final lerp along z feeds the output register.
  lerp_prod_t s10_p;
  corner_t    s10_a;

  always_ff @(posedge clk) begin
    s10_p       <= lerp_mul(ly[0], ly[1], w_pipe[9].z);
    s10_a       <= ly[0];
    noise_value <= lerp_add(s10_a, s10_p);
  end

  // Every accepted item strobes its result exactly once, when it leaves the
  // last stage, and no strobe appears without an item behind it.
  `VN3D_ASSERT_IMP(a_result_follows_item, clk, rst, accept, ##PIPE_DEPTH done,
                   "item lost in pipeline")
  `VN3D_ASSERT_IMP(a_no_spurious_result, clk, rst, done, $past(accept, PIPE_DEPTH),
                   "result without item")
  // An x lerp never leaves the span between its two corner values.
  `VN3D_ASSERT_IMP(a_lerp_x_bounded, clk, rst, vld[4],
                   ##2 ((lx[0] >= $past(cv[0], 2) && lx[0] <= $past(cv[1], 2)) ||
                        (lx[0] <= $past(cv[0], 2) && lx[0] >= $past(cv[1], 2))),
                   "x lerp out of span")

endmodule
